FILE: rtl/particle_euler_atlas_step_macros.svh
// assertion macros for the top design file
`ifndef PARTICLE_EULER_ATLAS_STEP_MACROS_SVH
`define PARTICLE_EULER_ATLAS_STEP_MACROS_SVH

// same-cycle implication
`define PEA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define PEA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

FILE: rtl/pea_pkg.sv
`timescale 1ns / 1ps

package pea_pkg;

   localparam int MaxAtlasRows = 16;
   localparam int CsrIdxW      = 3;
   localparam int CsrDataW     = 32;
   localparam int FracW        = 16;
   localparam int DivStepN     = 4;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_STEP_TIME     = 3'd0,
      CSR_GRAVITY_ACCEL = 3'd1,
      CSR_CAMERA_X      = 3'd2,
      CSR_CAMERA_Y      = 3'd3,
      CSR_CAMERA_Z      = 3'd4,
      CSR_ATLAS_ROWS    = 3'd5
   } csr_idx_type;

   // arithmetic results that ride alongside the divider
   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] nvy;
      logic        [31:0] nage;
      logic        [31:0] dist_sq;
      logic               alive;
      logic               life_zero;
   } res_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (x < -64'sh8000_0000)
         r = 32'sh8000_0000;
      else
         r = x[31:0];
      return r;
   endfunction

endpackage

FILE: rtl/particle_euler_atlas_step.sv
`timescale 1ns / 1ps
// channel   | direction | handshake               | payload
// req_      | in        | req_valid / req_ready   | particle record
// rsp_      | out       | rsp_valid / rsp_ready   | advanced record, tiles, distance
// csr_      | in        | csr_wr_en               | csr_index, csr_wdata
//
// one beat per cycle unless the pipe holds; 16 register stages at MAX_ATLAS_ROWS of 16: an input
// stage plus 15 divider stages of four quotient bits each.
// reset clears valid bits and loads register defaults, no clearing pass.
// the whole pipe moves as one: it holds only while the last stage waits on rsp_ready.

module particle_euler_atlas_step #(
   parameter int MAX_ATLAS_ROWS = pea_pkg::MaxAtlasRows
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [31:0] req_gravity_weight,
   input  logic [31:0] req_age,
   input  logic [31:0] req_lifespan,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_vel_y,
   output logic [31:0] rsp_new_age,
   output logic [31:0] rsp_camera_dist_sq,
   output logic rsp_alive,
   output logic [7:0] rsp_tile_first,
   output logic [7:0] rsp_tile_second,
   output logic [15:0] rsp_tile_blend,
   input  logic csr_wr_en,
   input  logic [pea_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pea_pkg::CsrDataW-1:0] csr_wdata
);
   import pea_pkg::*;

   `include "particle_euler_atlas_step_macros.svh"

   localparam int RowW    = $clog2(MAX_ATLAS_ROWS + 1);
   localparam int StgW    = $clog2(MAX_ATLAS_ROWS * MAX_ATLAS_ROWS + 1);
   localparam int NumW    = 32 + StgW;
   localparam int DivSt   = (NumW + FracW + DivStepN - 1) / DivStepN;
   localparam int QW      = DivSt * DivStepN;
   localparam int Lat     = 1 + DivSt;
   localparam int ArithSt = 6;
   localparam int Dly     = Lat - ArithSt;

   // configuration registers
   logic [15:0]        step_ff;
   logic signed [31:0] grav_ff, camx_ff, camy_ff, camz_ff;
   logic [4:0]         rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 16'd1092;
         grav_ff <= -32'sd3276800;
         camx_ff <= '0;
         camy_ff <= '0;
         camz_ff <= '0;
         rows_ff <= 5'd1;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_STEP_TIME:     step_ff <= csr_wdata[15:0];
            CSR_GRAVITY_ACCEL: grav_ff <= csr_wdata;
            CSR_CAMERA_X:      camx_ff <= csr_wdata;
            CSR_CAMERA_Y:      camy_ff <= csr_wdata;
            CSR_CAMERA_Z:      camz_ff <= csr_wdata;
            CSR_ATLAS_ROWS:    rows_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // atlas stage count from clamped rows
   logic [RowW-1:0] rows_c;
   logic [StgW-1:0] stages, smax;
   always_comb begin
      if (rows_ff == '0)
         rows_c = RowW'(1);
      else if (32'(rows_ff) > MAX_ATLAS_ROWS)
         rows_c = RowW'(MAX_ATLAS_ROWS);
      else
         rows_c = RowW'(rows_ff);
      stages = StgW'(rows_c) * StgW'(rows_c);
      smax   = stages - StgW'(1);
   end

   logic signed [16:0] dt;
   assign dt = signed'({1'b0, step_ff});

   // global advance and valid bits
   logic           en;
   logic [Lat-1:0] v_ff;
   assign en        = !v_ff[Lat-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = v_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else if (en)
         v_ff <= {v_ff[Lat-2:0], req_valid};
   end

   // stage 1: products, age step, progress numerator
   logic signed [63:0] gp_ff;
   logic signed [48:0] xd_ff, zd_ff;
   logic signed [31:0] px1_ff, py1_ff, pz1_ff, vy1_ff;
   logic [31:0]        nage1_ff, life1_ff;
   logic [NumW-1:0]    num_ff;
   logic [32:0]        age_sum;
   assign age_sum = {1'b0, req_age} + 33'(step_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         gp_ff    <= grav_ff * req_gravity_weight;
         xd_ff    <= req_vel_x * dt;
         zd_ff    <= req_vel_z * dt;
         px1_ff   <= req_pos_x;
         py1_ff   <= req_pos_y;
         pz1_ff   <= req_pos_z;
         vy1_ff   <= req_vel_y;
         nage1_ff <= age_sum[32] ? '1 : age_sum[31:0];
         life1_ff <= req_lifespan;
         num_ff   <= NumW'(req_age) * NumW'(stages);
      end
   end

   // stage 2: gravity times step, x and z positions
   logic signed [47:0] g2;
   logic signed [32:0] xs2, zs2;
   logic signed [64:0] gdt_ff;
   logic signed [31:0] nx2_ff, nz2_ff, py2_ff, vy2_ff;
   logic [31:0]        nage2_ff, life2_ff;
   assign g2  = gp_ff[63:16];
   assign xs2 = xd_ff[48:16];
   assign zs2 = zd_ff[48:16];

   always_ff @(posedge clock) begin
      if (en) begin
         gdt_ff   <= g2 * dt;
         nx2_ff   <= sat_s32(64'(px1_ff) + 64'(xs2));
         nz2_ff   <= sat_s32(64'(pz1_ff) + 64'(zs2));
         py2_ff   <= py1_ff;
         vy2_ff   <= vy1_ff;
         nage2_ff <= nage1_ff;
         life2_ff <= life1_ff;
      end
   end

   // stage 3: new y velocity
   logic signed [48:0] dv3;
   logic signed [31:0] nvy3_ff, nx3_ff, nz3_ff, py3_ff;
   logic [31:0]        nage3_ff, life3_ff;
   assign dv3 = gdt_ff[64:16];

   always_ff @(posedge clock) begin
      if (en) begin
         nvy3_ff  <= sat_s32(64'(vy2_ff) + 64'(dv3));
         nx3_ff   <= nx2_ff;
         nz3_ff   <= nz2_ff;
         py3_ff   <= py2_ff;
         nage3_ff <= nage2_ff;
         life3_ff <= life2_ff;
      end
   end

   // stage 4: y displacement
   logic signed [48:0] yd_ff;
   logic signed [31:0] nvy4_ff, nx4_ff, nz4_ff, py4_ff;
   logic [31:0]        nage4_ff, life4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         yd_ff    <= nvy3_ff * dt;
         nvy4_ff  <= nvy3_ff;
         nx4_ff   <= nx3_ff;
         nz4_ff   <= nz3_ff;
         py4_ff   <= py3_ff;
         nage4_ff <= nage3_ff;
         life4_ff <= life3_ff;
      end
   end

   // stage 5: y position and camera offsets
   logic signed [32:0] ys5, dx5, dy5, dz5;
   logic signed [31:0] ny5;
   logic [32:0]        mx_ff, my_ff, mz_ff;
   logic signed [31:0] nvy5_ff, nx5_ff, ny5_ff, nz5_ff;
   logic [31:0]        nage5_ff, life5_ff;
   always_comb begin
      ys5 = yd_ff[48:16];
      ny5 = sat_s32(64'(py4_ff) + 64'(ys5));
      dx5 = 33'(camx_ff) - 33'(nx4_ff);
      dy5 = 33'(camy_ff) - 33'(ny5);
      dz5 = 33'(camz_ff) - 33'(nz4_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= dx5[32] ? 33'(-dx5) : 33'(dx5);
         my_ff    <= dy5[32] ? 33'(-dy5) : 33'(dy5);
         mz_ff    <= dz5[32] ? 33'(-dz5) : 33'(dz5);
         nvy5_ff  <= nvy4_ff;
         nx5_ff   <= nx4_ff;
         ny5_ff   <= ny5;
         nz5_ff   <= nz4_ff;
         nage5_ff <= nage4_ff;
         life5_ff <= life4_ff;
      end
   end

   // stage 6: squares of the offsets
   logic [47:0]        sqx_ff, sqy_ff, sqz_ff;
   logic               big6_ff;
   logic signed [31:0] nvy6_ff, nx6_ff, ny6_ff, nz6_ff;
   logic [31:0]        nage6_ff, life6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= mx_ff[23:0] * mx_ff[23:0];
         sqy_ff   <= my_ff[23:0] * my_ff[23:0];
         sqz_ff   <= mz_ff[23:0] * mz_ff[23:0];
         big6_ff  <= (|mx_ff[32:24]) || (|my_ff[32:24]) || (|mz_ff[32:24]);
         nvy6_ff  <= nvy5_ff;
         nx6_ff   <= nx5_ff;
         ny6_ff   <= ny5_ff;
         nz6_ff   <= nz5_ff;
         nage6_ff <= nage5_ff;
         life6_ff <= life5_ff;
      end
   end

   // stage 7: distance sum, alive flag, then the delay line
   logic [49:0] sum7;
   logic [33:0] sh7;
   res_type     res7;
   res_type     dly_ff [Dly];
   always_comb begin
      sum7           = 50'(sqx_ff) + 50'(sqy_ff) + 50'(sqz_ff);
      sh7            = sum7[49:16];
      res7.nx        = nx6_ff;
      res7.ny        = ny6_ff;
      res7.nz        = nz6_ff;
      res7.nvy       = nvy6_ff;
      res7.nage      = nage6_ff;
      res7.dist_sq   = (big6_ff || (|sh7[33:32])) ? '1 : sh7[31:0];
      res7.alive     = nage6_ff < life6_ff;
      res7.life_zero = life6_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= res7;
         for (int i = 1; i < Dly; i++)
            dly_ff[i] <= dly_ff[i-1];
      end
   end

   // atlas progress division
   logic [QW-1:0] quo;
   pea_div #(.NUM_W(NumW)) u_div (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (life1_ff),
      .quo   (quo)
   );

   // tile selection at the last stage
   res_type             res_o;
   logic [QW-FracW-1:0] ipart;
   logic [StgW-1:0]     idx1, idx2;
   always_comb begin
      res_o = dly_ff[Dly-1];
      ipart = quo[QW-1:FracW];
      if (res_o.life_zero || ipart > (QW-FracW)'(smax))
         idx1 = smax;
      else
         idx1 = ipart[StgW-1:0];
      idx2 = (idx1 < smax) ? idx1 + StgW'(1) : idx1;
   end

   assign rsp_new_pos_x      = res_o.nx;
   assign rsp_new_pos_y      = res_o.ny;
   assign rsp_new_pos_z      = res_o.nz;
   assign rsp_new_vel_y      = res_o.nvy;
   assign rsp_new_age        = res_o.nage;
   assign rsp_camera_dist_sq = res_o.dist_sq;
   assign rsp_alive          = res_o.alive;
   assign rsp_tile_first     = 8'(idx1);
   assign rsp_tile_second    = 8'(idx2);
   assign rsp_tile_blend     = res_o.life_zero ? 16'd0 : quo[FracW-1:0];

   // checks
   `PEA_ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, v_ff[0])
   `PEA_ASSERT_IMPL(a_tile_range, clock, reset, rsp_valid, idx1 <= smax && idx2 <= smax)
   `PEA_ASSERT_IMPL(a_alive_age, clock, reset, rsp_valid && rsp_alive,
                    rsp_new_age != 32'hFFFF_FFFF)

endmodule

FILE: rtl/pea_div.sv
`timescale 1ns / 1ps

module pea_div #(
   parameter int NUM_W = 40
) (
   input  logic clock,
   input  logic en,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0] den,
   output logic [((NUM_W+pea_pkg::FracW+pea_pkg::DivStepN-1)/pea_pkg::DivStepN)
                 *pea_pkg::DivStepN-1:0] quo
);
   import pea_pkg::*;

   localparam int DivW   = NUM_W + FracW;
   localparam int Stages = (DivW + DivStepN - 1) / DivStepN;
   localparam int QW     = Stages * DivStepN;

   logic [31:0]   rem_ff [Stages];
   logic [QW-1:0] rq_ff  [Stages];
   logic [31:0]   den_ff [Stages];
   logic [31:0]   rem_in [Stages];
   logic [QW-1:0] rq_in  [Stages];

   // restoring division, dividend shifts out the top while quotient bits shift in
   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [31:0]   r_src, d_src;
      logic [QW-1:0] q_src;

      // stage inputs: the operands at the head, the previous stage after it
      if (s == 0) begin : g_head
         assign r_src = '0;
         assign q_src = QW'({num, {FracW{1'b0}}});
         assign d_src = den;
      end else begin : g_body
         assign r_src = rem_ff[s-1];
         assign q_src = rq_ff[s-1];
         assign d_src = den_ff[s-1];
      end

      always_comb begin
         logic [31:0]   r;
         logic [QW-1:0] q;
         logic [31:0]   d;
         logic [32:0]   t;
         r = r_src;
         q = q_src;
         d = d_src;
         for (int k = 0; k < DivStepN; k++) begin
            t = {r, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
               t    = t - {1'b0, d};
               q[0] = 1'b1;
            end
            r = t[31:0];
         end
         rem_in[s] = r;
         rq_in[s]  = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            rq_ff[s]  <= rq_in[s];
            den_ff[s] <= d_src;
         end
      end
   end

   assign quo = rq_ff[Stages-1];

endmodule

FILE: sim/pea_frame_checker.sv
`timescale 1ns / 1ps

module pea_frame_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic signed [31:0] req_gravity_weight,
   input  logic [31:0] req_age,
   input  logic [31:0] req_lifespan,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [31:0] rsp_new_pos_x,
   input  logic signed [31:0] rsp_new_pos_y,
   input  logic signed [31:0] rsp_new_pos_z,
   input  logic signed [31:0] rsp_new_vel_y,
   input  logic [31:0] rsp_new_age,
   input  logic [31:0] rsp_camera_dist_sq,
   input  logic rsp_alive,
   input  logic [7:0] rsp_tile_first,
   input  logic [7:0] rsp_tile_second,
   input  logic [15:0] rsp_tile_blend,
   input  logic csr_wr_en,
   input  logic [pea_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pea_pkg::CsrDataW-1:0] csr_wdata,
   output int fail_count,
   output int pending
);
   import pea_pkg::*;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_y;
      logic [31:0] age;
      logic [31:0] dist_sq;
      logic alive;
      logic [7:0] tile_a;
      logic [7:0] tile_b;
      logic [15:0] blend;
   } frame_out_type;

   // shadow copy of the registers
   logic [15:0] step_time;
   logic signed [31:0] gravity_accel;
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic [4:0] atlas_rows;

   frame_out_type frame_q[$];

   function automatic longint clamp_s32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint abs_val(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // advance one particle by one frame
   function automatic frame_out_type advance_particle(
      input logic signed [31:0] px, py, pz, vx, vy, vz, gw,
      input logic [31:0] age, life);
      frame_out_type r;
      longint dt, g, nvy, nx, ny, nz, dx, dy, dz, ssum;
      longint unsigned nage, rows, stages, prog, idx;
      dt = longint'(step_time);
      g = (longint'(gravity_accel) * longint'(gw)) >>> 16;
      nvy = clamp_s32(longint'(vy) + ((g * dt) >>> 16));
      nx = clamp_s32(longint'(px) + ((longint'(vx) * dt) >>> 16));
      ny = clamp_s32(longint'(py) + ((nvy * dt) >>> 16));
      nz = clamp_s32(longint'(pz) + ((longint'(vz) * dt) >>> 16));
      dx = abs_val(longint'(cam_x) - nx);
      dy = abs_val(longint'(cam_y) - ny);
      dz = abs_val(longint'(cam_z) - nz);
      // any axis at 2^24 or beyond is off the scale anyway
      if (dx >= (64'sd1 << 24) || dy >= (64'sd1 << 24) || dz >= (64'sd1 << 24))
         r.dist_sq = 32'hFFFF_FFFF;
      else begin
         ssum = (dx * dx + dy * dy + dz * dz) >>> 16;
         r.dist_sq = (ssum > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF : ssum[31:0];
      end
      nage = longint'(age) + dt;
      if (nage > 64'h FFFF_FFFF) nage = 64'h FFFF_FFFF;
      r.alive = (nage < longint'(life));
      // atlas progress from the age before the step
      rows = atlas_rows;
      if (rows < 1) rows = 1;
      if (rows > MaxAtlasRows) rows = MaxAtlasRows;
      stages = rows * rows;
      if (life == 0) begin
         idx = stages - 1;
         r.blend = '0;
      end else begin
         prog = ((longint'(age) * stages) << 16) / longint'(life);
         idx = prog >> 16;
         r.blend = prog[15:0];
         if (idx > stages - 1) idx = stages - 1;
      end
      r.tile_a = idx[7:0];
      r.tile_b = (idx < stages - 1) ? idx[7:0] + 8'd1 : idx[7:0];
      r.pos_x = nx[31:0];
      r.pos_y = ny[31:0];
      r.pos_z = nz[31:0];
      r.vel_y = nvy[31:0];
      r.age = nage[31:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // register snoop
   always @(posedge clock) begin
      if (reset) begin
         step_time <= 16'd1092;
         gravity_accel <= -32'sd3276800;
         cam_x <= '0;
         cam_y <= '0;
         cam_z <= '0;
         atlas_rows <= 5'd1;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_STEP_TIME: step_time <= csr_wdata[15:0];
            CSR_GRAVITY_ACCEL: gravity_accel <= csr_wdata;
            CSR_CAMERA_X: cam_x <= csr_wdata;
            CSR_CAMERA_Y: cam_y <= csr_wdata;
            CSR_CAMERA_Z: cam_z <= csr_wdata;
            CSR_ATLAS_ROWS: atlas_rows <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // predict on request beats, compare on response beats
   always @(posedge clock) begin
      frame_out_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            frame_q.push_back(advance_particle(req_pos_x, req_pos_y, req_pos_z,
               req_vel_x, req_vel_y, req_vel_z, req_gravity_weight,
               req_age, req_lifespan));
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               $display("unexpected response beat at %0t", $realtime);
               fail_count++;
            end else begin
               want = frame_q.pop_front();
               if (rsp_new_pos_x !== want.pos_x)
                  report_mismatch("new_pos_x", rsp_new_pos_x, want.pos_x);
               if (rsp_new_pos_y !== want.pos_y)
                  report_mismatch("new_pos_y", rsp_new_pos_y, want.pos_y);
               if (rsp_new_pos_z !== want.pos_z)
                  report_mismatch("new_pos_z", rsp_new_pos_z, want.pos_z);
               if (rsp_new_vel_y !== want.vel_y)
                  report_mismatch("new_vel_y", rsp_new_vel_y, want.vel_y);
               if (rsp_new_age !== want.age)
                  report_mismatch("new_age", rsp_new_age, want.age);
               if (rsp_camera_dist_sq !== want.dist_sq)
                  report_mismatch("camera_dist_sq", rsp_camera_dist_sq, want.dist_sq);
               if (rsp_alive !== want.alive)
                  report_mismatch("alive", rsp_alive, want.alive);
               if (rsp_tile_first !== want.tile_a)
                  report_mismatch("tile_first", rsp_tile_first, want.tile_a);
               if (rsp_tile_second !== want.tile_b)
                  report_mismatch("tile_second", rsp_tile_second, want.tile_b);
               if (rsp_tile_blend !== want.blend)
                  report_mismatch("tile_blend", rsp_tile_blend, want.blend);
            end
         end
         pending <= frame_q.size();
      end
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pea_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic signed [31:0] req_gravity_weight = '0;
   logic [31:0] req_age = '0, req_lifespan = 32'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z, rsp_new_vel_y;
   logic [31:0] rsp_new_age, rsp_camera_dist_sq;
   logic rsp_alive;
   logic [7:0] rsp_tile_first, rsp_tile_second;
   logic [15:0] rsp_tile_blend;
   logic csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   int fail_count, pending;
   int req_beats = 0, rsp_beats = 0, cycles = 0;
   bit burst_tx = 0, burst_rx = 0;

   particle_euler_atlas_step dut (.*);

   pea_frame_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   // beat counters, read back at the falling edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready) req_beats <= req_beats + 1;
      if (!reset && rsp_valid && rsp_ready) rsp_beats <= rsp_beats + 1;
   end

   always @(posedge clock) begin
      if (cycles == CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, bursts with none, one long hold-off
   initial begin
      int gap, n;
      bit held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) burst_rx = ~burst_rx;
         gap = burst_rx ? 0 : $urandom_range(0, 16);
         if (!held && rsp_beats >= 300) begin
            held = 1;
            gap = 400;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         n = rsp_beats;
         do @(negedge clock); while (rsp_beats == n);
      end
   end

   task automatic send_particle(input logic [31:0] px, py, pz, vx, vy, vz, gw, age, life);
      int gap, n;
      if ($urandom_range(0, 31) == 0) burst_tx = ~burst_tx;
      gap = burst_tx ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_gravity_weight <= gw;
      req_age <= age;
      req_lifespan <= life;
      n = req_beats;
      do @(negedge clock); while (req_beats == n);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // let the pipe empty before touching registers
   task automatic drain_pipe();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while ((pending != 0 || rsp_beats != req_beats) && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] dt, input logic [31:0] grav,
                                input logic [31:0] cx, cy, cz, input logic [4:0] rows);
      write_csr(CSR_STEP_TIME, {16'd0, dt});
      write_csr(CSR_GRAVITY_ACCEL, grav);
      write_csr(CSR_CAMERA_X, cx);
      write_csr(CSR_CAMERA_Y, cy);
      write_csr(CSR_CAMERA_Z, cz);
      write_csr(CSR_ATLAS_ROWS, {27'd0, rows});
   endtask

   // mostly moderate Q16.16 values, some full-range ones for saturation
   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   task automatic random_particles(input int count);
      logic [31:0] life, age;
      repeat (count) begin
         life = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 32'h00FF_FFFF);
         case ($urandom_range(0, 4))
            0: age = $urandom;
            1: age = life - $urandom_range(0, 2000);
            default: age = $urandom_range(0, life);
         endcase
         send_particle(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                       rand_q(), age, life);
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults
      random_particles(200);
      drain_pipe();

      // directed corners at long step, strong gravity, 4x4 atlas
      load_settings(16'hFFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 5'd4);
      send_particle(0, 0, 0, 0, 0, 0, 0, 0, 32'd1);
      send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF);
      send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF);
      send_particle(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'd100, 32'd0);
      send_particle(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000,
                    32'd99, 32'd100);
      send_particle(0, 0, 0, 32'h10000, 32'h7FFF_0000, 32'h10000, 32'h10000,
                    32'd200, 32'd100);
      send_particle(32'h0FFF_FFFF, 0, 0, 0, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_FFFF);
      send_particle(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 0, 0, 0, 0,
                    32'd50, 32'd100);
      send_particle(32'h00FF_0000, 32'hFF01_0000, 32'h0, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15, 32'd16);
      send_particle(0, 0, 0, 0, 0, 0, 0, 32'd16, 32'd16);
      random_particles(240);
      drain_pipe();

      // zero step, most negative gravity, far camera, zero rows
      load_settings(16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 5'd0);
      send_particle(0, 0, 0, 0, 0, 0, 0, 0, 32'd1);
      random_particles(200);
      drain_pipe();

      // largest atlas, rows above the maximum, camera near origin
      load_settings(16'd4000, -32'sd3276800, 32'h0001_0000, 32'hFFFF_0000,
                    32'h0000_8000, 5'd31);
      send_particle(0, 0, 0, 0, 0, 0, 0, 32'd255, 32'd256);
      random_particles(240);
      drain_pipe();

      load_settings(16'd2184, 32'hFFF6_0000, 32'h0, 32'h0, 32'h0, 5'd16);
      random_particles(300);
      drain_pipe();

      if (fail_count == 0 && pending == 0 && rsp_beats == req_beats)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pea_pkg.sv
rtl/pea_div.sv
rtl/particle_euler_atlas_step.sv
sim/pea_frame_checker.sv
sim/tb_top.sv
